>>> rtl/efa_pkg.sv
// ----------------------------------------------------------------------------
// efa_pkg: encoder frequency adjuster shared definitions
// Beat types, request and step codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package efa_pkg;

  localparam int FREQ_W    = 24;
  localparam int STEP_W    = 20;
  localparam int TICKS_W   = 8;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [FREQ_W-1:0]  RESET_FREQ    = FREQ_W'(1000);
  localparam logic [STEP_W-1:0]  RESET_STEP    = STEP_W'(1);
  localparam logic [TICKS_W-1:0] RESET_TICKS   = TICKS_W'(4);
  localparam logic [CNT_W-1:0]   RESET_CONFIRM = CNT_W'(2);
  localparam logic [FREQ_W-1:0]  RESET_MAX     = FREQ_W'(15625);
  localparam logic [FREQ_W-1:0]  RESET_MIN     = FREQ_W'(1);

  typedef enum logic [1:0] {
    REQ_PULSE = 2'd0,
    REQ_DIR   = 2'd1,
    REQ_TICK  = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } stepped_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE     = 3'd0,
    CFG_LOCKOUT_TICKS = 3'd1,
    CFG_CONFIRM_COUNT = 3'd2,
    CFG_MAX_FREQUENCY = 3'd3,
    CFG_MIN_FREQUENCY = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       pulse_level;
    logic       dir_level;
  } in_beat_t;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic [1:0]        stepped;
    logic              lockout_active;
  } out_beat_t;

endpackage

>>> rtl/encoder_frequency_adjuster_core.sv
// ----------------------------------------------------------------------------
// encoder_frequency_adjuster_core: rotary encoder to frequency setting
// Turns encoder pin events and millisecond ticks into a clamped frequency.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  efa_pkg::in_beat_t
//  out_     output     out_valid/out_stall efa_pkg::out_beat_t
//  cfg_     input      cfg_we             cfg_index, cfg_data
//
//  One beat per cycle while in_stall is low; each result is registered.
//  State updates in a single pass between the input and the output register.
//  A two-entry output register and skid slot let one more beat in while the
//  result side stalls; in_stall is the registered skid-full flag.
//  Synchronous active-low reset restores all but the result data registers.
// ----------------------------------------------------------------------------
module encoder_frequency_adjuster_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  efa_pkg::in_beat_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output efa_pkg::out_beat_t              out_data,
  input  logic                            cfg_we,
  input  logic [efa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [efa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [efa_pkg::STEP_W-1:0]  step_r;
  logic [efa_pkg::TICKS_W-1:0] ticks_r;
  logic [efa_pkg::CNT_W-1:0]   confirm_r;
  logic [efa_pkg::FREQ_W-1:0]  max_r;
  logic [efa_pkg::FREQ_W-1:0]  min_r;

  logic [efa_pkg::FREQ_W-1:0]  freq_r, freq_nxt;
  logic                        phase_r, phase_nxt;
  logic [efa_pkg::CNT_W-1:0]   up_r, up_nxt;
  logic [efa_pkg::CNT_W-1:0]   down_r, down_nxt;
  logic                        lock_r, lock_nxt;
  logic [efa_pkg::TICKS_W-1:0] timer_r, timer_nxt;

  efa_pkg::out_beat_t out_r, out_nxt;
  efa_pkg::out_beat_t skd_r, skd_nxt;
  efa_pkg::out_beat_t res;
  logic               out_valid_r, out_valid_nxt;
  logic               skd_valid_r, skd_valid_nxt;

  logic                        acc;
  logic                        same;
  logic                        is_pin;
  logic                        cw;
  logic [efa_pkg::CNT_W-1:0]   up_inc;
  logic [efa_pkg::CNT_W-1:0]   down_inc;
  logic [efa_pkg::TICKS_W-1:0] timer_inc;
  logic [efa_pkg::FREQ_W:0]    freq_pre;
  logic [efa_pkg::FREQ_W-1:0]  freq_hi;
  logic [1:0]                  stepped;

  assign acc       = in_valid && !skd_valid_r;
  assign in_stall  = skd_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= efa_pkg::RESET_STEP;
      ticks_r   <= efa_pkg::RESET_TICKS;
      confirm_r <= efa_pkg::RESET_CONFIRM;
      max_r     <= efa_pkg::RESET_MAX;
      min_r     <= efa_pkg::RESET_MIN;
    end else if (cfg_we) begin
      case (cfg_index)
        efa_pkg::CFG_STEP_SIZE:     step_r    <= cfg_data[efa_pkg::STEP_W-1:0];
        efa_pkg::CFG_LOCKOUT_TICKS: ticks_r   <= cfg_data[efa_pkg::TICKS_W-1:0];
        efa_pkg::CFG_CONFIRM_COUNT: confirm_r <= cfg_data[efa_pkg::CNT_W-1:0];
        efa_pkg::CFG_MAX_FREQUENCY: max_r     <= cfg_data[efa_pkg::FREQ_W-1:0];
        efa_pkg::CFG_MIN_FREQUENCY: min_r     <= cfg_data[efa_pkg::FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    same      = (in_data.pulse_level == in_data.dir_level);
    is_pin    = (in_data.req_type == efa_pkg::REQ_PULSE) ||
                (in_data.req_type == efa_pkg::REQ_DIR);
    cw        = (in_data.req_type == efa_pkg::REQ_PULSE) ? same : !same;
    up_inc    = up_r + efa_pkg::CNT_W'(1);
    down_inc  = down_r + efa_pkg::CNT_W'(1);
    timer_inc = timer_r + efa_pkg::TICKS_W'(1);

    freq_pre  = {1'b0, freq_r};
    phase_nxt = phase_r;
    up_nxt    = up_r;
    down_nxt  = down_r;
    lock_nxt  = lock_r;
    timer_nxt = timer_r;
    stepped   = efa_pkg::STEP_NONE;

    if (is_pin && !lock_r) begin
      if (cw) begin
        down_nxt = '0;
        if (phase_r != same) begin
          up_nxt = up_inc;
          if (up_inc == confirm_r) begin
            freq_pre = {1'b0, freq_r} + {{(efa_pkg::FREQ_W+1-efa_pkg::STEP_W){1'b0}}, step_r};
            up_nxt   = '0;
            stepped  = efa_pkg::STEP_UP;
          end
        end
      end else begin
        up_nxt = '0;
        if (phase_r != same) begin
          down_nxt = down_inc;
          if (down_inc == confirm_r) begin
            if (freq_r > efa_pkg::FREQ_W'(step_r)) begin
              freq_pre = {1'b0, freq_r - efa_pkg::FREQ_W'(step_r)};
            end else begin
              freq_pre = (efa_pkg::FREQ_W+1)'(step_r);
            end
            down_nxt = '0;
            stepped  = efa_pkg::STEP_DOWN;
          end
        end
      end
      phase_nxt = same;
      lock_nxt  = 1'b1;
    end else if ((in_data.req_type == efa_pkg::REQ_TICK) && lock_r) begin
      if (timer_inc >= ticks_r) begin
        timer_nxt = '0;
        lock_nxt  = 1'b0;
      end else begin
        timer_nxt = timer_inc;
      end
    end

    if (freq_pre > {1'b0, max_r}) begin
      freq_hi = max_r;
    end else begin
      freq_hi = freq_pre[efa_pkg::FREQ_W-1:0];
    end
    if (freq_hi < min_r) begin
      freq_nxt = min_r;
    end else begin
      freq_nxt = freq_hi;
    end

    res.frequency      = freq_nxt;
    res.stepped        = stepped;
    res.lockout_active = lock_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r  <= efa_pkg::RESET_FREQ;
      phase_r <= 1'b0;
      up_r    <= '0;
      down_r  <= '0;
      lock_r  <= 1'b0;
      timer_r <= '0;
    end else if (acc) begin
      freq_r  <= freq_nxt;
      phase_r <= phase_nxt;
      up_r    <= up_nxt;
      down_r  <= down_nxt;
      lock_r  <= lock_nxt;
      timer_r <= timer_nxt;
    end
  end

  always_comb begin
    out_nxt       = out_r;
    skd_nxt       = skd_r;
    out_valid_nxt = out_valid_r;
    skd_valid_nxt = skd_valid_r;
    if (!out_valid_r || !out_stall) begin
      if (skd_valid_r) begin
        out_nxt       = skd_r;
        out_valid_nxt = 1'b1;
        skd_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = acc;
      end
    end else if (acc) begin
      skd_nxt       = res;
      skd_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skd_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skd_valid_r <= skd_valid_nxt;
    end
    out_r <= out_nxt;
    skd_r <= skd_nxt;
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skd_valid_r |-> out_valid_r)
    else $error("skid slot full while output register empty");

  a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
    acc && out_valid_r && out_stall |=> skd_valid_r)
    else $error("stalled beat not captured in skid slot");

  a_step_locks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.stepped != efa_pkg::STEP_NONE) |-> out_r.lockout_active)
    else $error("step reported without lockout");

  a_timer_locked: assert property (@(posedge clk) disable iff (!rst_n)
    (timer_r != '0) |-> lock_r)
    else $error("lockout timer running while unlocked");

endmodule

>>> tb/tb_encoder_frequency_adjuster_core.sv
// ----------------------------------------------------------------------------
// tb_encoder_frequency_adjuster_core: self-checking bench for the adjuster
// Feeds quadrature detent sequences, pin noise and millisecond ticks under a
// series of register settings and handshake pressure. Every result beat is
// checked field by field against an in-bench model of the decoder state.
// ----------------------------------------------------------------------------
module tb_encoder_frequency_adjuster_core;

  localparam logic [1:0] REQ_UNUSED     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         DRAIN_CYCLES   = 6;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  efa_pkg::in_beat_t              in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  efa_pkg::out_beat_t             out_data;
  logic                           cfg_we = 1'b0;
  logic [efa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [efa_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  encoder_frequency_adjuster_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // model registers and decoder state
  logic [efa_pkg::STEP_W-1:0]  m_step    = efa_pkg::RESET_STEP;
  logic [efa_pkg::TICKS_W-1:0] m_ticks   = efa_pkg::RESET_TICKS;
  logic [efa_pkg::CNT_W-1:0]   m_confirm = efa_pkg::RESET_CONFIRM;
  logic [efa_pkg::FREQ_W-1:0]  m_max     = efa_pkg::RESET_MAX;
  logic [efa_pkg::FREQ_W-1:0]  m_min     = efa_pkg::RESET_MIN;
  logic [efa_pkg::FREQ_W-1:0]  m_freq    = efa_pkg::RESET_FREQ;
  logic                        m_phase   = 1'b0;
  logic [efa_pkg::CNT_W-1:0]   m_up      = '0;
  logic [efa_pkg::CNT_W-1:0]   m_down    = '0;
  logic                        m_locked  = 1'b0;
  logic [efa_pkg::TICKS_W-1:0] m_timer   = '0;

  efa_pkg::in_beat_t  pending_beats[$];
  efa_pkg::out_beat_t freq_expected[$];
  int        n_pushed = 0;
  int        n_in = 0;
  int        n_out = 0;
  int        n_errors = 0;
  int        n_settings = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  bit        beat_taken = 1'b0;
  logic      gen_pulse = 1'b0;
  logic      gen_dir = 1'b0;

  function automatic efa_pkg::out_beat_t advance_encoder(efa_pkg::in_beat_t b);
    efa_pkg::out_beat_t       r;
    logic [efa_pkg::FREQ_W:0] acc;
    logic                     same;
    logic                     cw;
    efa_pkg::stepped_t        st;
    st   = efa_pkg::STEP_NONE;
    acc  = {1'b0, m_freq};
    same = (b.pulse_level == b.dir_level);
    if (b.req_type == efa_pkg::REQ_PULSE || b.req_type == efa_pkg::REQ_DIR) begin
      if (!m_locked) begin
        cw = (b.req_type == efa_pkg::REQ_PULSE) ? same : !same;
        if (cw) begin
          m_down = '0;
          if (m_phase != same) begin
            m_up = m_up + 1'b1;
            if (m_up == m_confirm) begin
              acc  = acc + m_step;
              m_up = '0;
              st   = efa_pkg::STEP_UP;
            end
          end
        end else begin
          m_up = '0;
          if (m_phase != same) begin
            m_down = m_down + 1'b1;
            if (m_down == m_confirm) begin
              if (acc > m_step) acc = acc - m_step;
              else acc = {1'b0, 4'b0, m_step};
              m_down = '0;
              st     = efa_pkg::STEP_DOWN;
            end
          end
        end
        m_phase  = same;
        m_locked = 1'b1;
      end
    end else if (b.req_type == efa_pkg::REQ_TICK) begin
      if (m_locked) begin
        m_timer = m_timer + 1'b1;
        if (m_timer >= m_ticks) begin
          m_timer  = '0;
          m_locked = 1'b0;
        end
      end
    end
    if (acc > m_max) acc = {1'b0, m_max};
    if (acc < m_min) acc = {1'b0, m_min};
    m_freq           = acc[efa_pkg::FREQ_W-1:0];
    r.frequency      = m_freq;
    r.stepped        = st;
    r.lockout_active = m_locked;
    return r;
  endfunction

  // sample and check
  always @(posedge clk) begin
    efa_pkg::out_beat_t want;
    bit                 busy;
    if (rst_n) begin
      busy = 1'b0;
      if (out_valid && !out_stall) begin
        busy  = 1'b1;
        n_out = n_out + 1;
        if (freq_expected.size() == 0) begin
          $error("result beat with nothing expected: frequency %0d", out_data.frequency);
          n_errors = n_errors + 1;
        end else begin
          want = freq_expected.pop_front();
          if (out_data.frequency !== want.frequency) begin
            $error("frequency: expected %0d, got %0d", want.frequency, out_data.frequency);
            n_errors = n_errors + 1;
          end
          if (out_data.stepped !== want.stepped) begin
            $error("stepped: expected %0d, got %0d", want.stepped, out_data.stepped);
            n_errors = n_errors + 1;
          end
          if (out_data.lockout_active !== want.lockout_active) begin
            $error("lockout_active: expected %0d, got %0d",
                   want.lockout_active, out_data.lockout_active);
            n_errors = n_errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        busy = 1'b1;
        freq_expected.push_back(advance_encoder(in_data));
        n_in       = n_in + 1;
        beat_taken = 1'b1;
      end
      if (busy) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // drive input beats and result stall
  always @(negedge clk) begin
    logic              nv;
    efa_pkg::in_beat_t nd;
    nv = in_valid;
    nd = in_data;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_valid || beat_taken) begin
      nv = 1'b0;
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nd = pending_beats.pop_front();
        nv = 1'b1;
      end
    end
    beat_taken = 1'b0;
    in_valid  <= nv;
    in_data   <= nd;
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  task automatic push_beat(logic [1:0] req, logic pulse, logic dir);
    efa_pkg::in_beat_t b;
    b.req_type    = req;
    b.pulse_level = pulse;
    b.dir_level   = dir;
    pending_beats.push_back(b);
    n_pushed = n_pushed + 1;
  endtask

  task automatic push_ticks(int n);
    repeat (n) push_beat(efa_pkg::REQ_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // advance the encoder one edge in the given direction
  task automatic push_move(logic cw);
    if (cw == (gen_pulse != gen_dir)) begin
      gen_pulse = ~gen_pulse;
      push_beat(efa_pkg::REQ_PULSE, gen_pulse, gen_dir);
    end else begin
      gen_dir = ~gen_dir;
      push_beat(efa_pkg::REQ_DIR, gen_pulse, gen_dir);
    end
  endtask

  task automatic queue_random(int budget);
    int   used;
    int   run_left;
    int   pick;
    int   n_ticks;
    int   n_extra;
    logic cw;
    used     = 0;
    run_left = 0;
    cw       = 1'b1;
    while (used < budget) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        if (run_left == 0) begin
          cw       = 1'($urandom_range(1));
          run_left = $urandom_range(40, 1);
        end
        run_left = run_left - 1;
        push_move(cw);
        n_ticks = (m_ticks == 0) ? 1 : int'(m_ticks);
        if ($urandom_range(9) == 0) n_ticks = $urandom_range(n_ticks);
        push_ticks(n_ticks);
        used = used + 1 + n_ticks;
        if ($urandom_range(7) == 0) begin
          n_extra = $urandom_range(3, 1);
          push_ticks(n_extra);
          used = used + n_extra;
        end
      end else if (pick < 92) begin
        push_beat(2'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        used = used + 1;
      end else if (pick < 97) begin
        push_ticks(1);
        used = used + 1;
      end else begin
        push_beat(REQ_UNUSED, 1'($urandom_range(1)), 1'($urandom_range(1)));
        used = used + 1;
      end
    end
  endtask

  task automatic write_reg(efa_pkg::cfg_index_t idx, logic [efa_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      efa_pkg::CFG_STEP_SIZE:     m_step    = val[efa_pkg::STEP_W-1:0];
      efa_pkg::CFG_LOCKOUT_TICKS: m_ticks   = val[efa_pkg::TICKS_W-1:0];
      efa_pkg::CFG_CONFIRM_COUNT: m_confirm = val[efa_pkg::CNT_W-1:0];
      efa_pkg::CFG_MAX_FREQUENCY: m_max     = val[efa_pkg::FREQ_W-1:0];
      efa_pkg::CFG_MIN_FREQUENCY: m_min     = val[efa_pkg::FREQ_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(logic [efa_pkg::CFG_DATA_W-1:0] step,
                               logic [efa_pkg::CFG_DATA_W-1:0] ticks,
                               logic [efa_pkg::CFG_DATA_W-1:0] confirm,
                               logic [efa_pkg::CFG_DATA_W-1:0] maxf,
                               logic [efa_pkg::CFG_DATA_W-1:0] minf);
    write_reg(efa_pkg::CFG_STEP_SIZE, step);
    write_reg(efa_pkg::CFG_LOCKOUT_TICKS, ticks);
    write_reg(efa_pkg::CFG_CONFIRM_COUNT, confirm);
    write_reg(efa_pkg::CFG_MAX_FREQUENCY, maxf);
    write_reg(efa_pkg::CFG_MIN_FREQUENCY, minf);
    n_settings = n_settings + 1;
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    while (n_in != n_pushed || n_out != n_in) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_pressure(int phase_no);
    case (phase_no % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 53; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 53; end
      default: begin send_idle_pct = 25; stall_pct = 25; end
    endcase
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: idle tick, unused code, counting, lockout, reversal
    push_ticks(1);
    push_beat(REQ_UNUSED, 1'b1, 1'b1);
    push_beat(efa_pkg::REQ_PULSE, 1'b1, 1'b1);
    push_beat(efa_pkg::REQ_DIR, 1'b1, 1'b0);
    push_ticks(4);
    push_beat(efa_pkg::REQ_DIR, 1'b1, 1'b0);
    push_ticks(4);
    push_beat(efa_pkg::REQ_PULSE, 1'b0, 1'b1);
    push_ticks(4);
    push_beat(efa_pkg::REQ_DIR, 1'b0, 1'b0);
    push_beat(efa_pkg::REQ_PULSE, 1'b1, 1'b0);
    push_ticks(4);
    gen_pulse = 1'b0;
    gen_dir   = 1'b0;
    wait_drained();

    apply_setting(24'd1, 24'd1, 24'd1, 24'hFFFFFF, 24'd1);
    set_pressure(1);
    queue_random(250);
    wait_drained();

    apply_setting(24'd1000000, 24'd2, 24'd1, 24'hFFFFFF, 24'd1);
    set_pressure(2);
    queue_random(250);
    wait_drained();

    apply_setting(24'd1000000, 24'd3, 24'd2, 24'd3000000, 24'd500000);
    set_pressure(3);
    queue_random(250);
    wait_drained();

    apply_setting(24'd7, 24'd255, 24'd1, 24'd1200, 24'd900);
    set_pressure(4);
    queue_random(400);
    wait_drained();

    // min above max
    apply_setting(24'd50, 24'd1, 24'd3, 24'd1, 24'hFFFFFF);
    set_pressure(5);
    queue_random(150);
    wait_drained();

    // zero lockout and zero confirm registers
    apply_setting(24'd100, 24'd0, 24'd0, 24'd2000, 24'd1);
    set_pressure(6);
    queue_random(200);
    wait_drained();

    apply_setting(24'($urandom_range(1000000, 1)), 24'($urandom_range(8, 1)),
                  24'($urandom_range(4, 1)), 24'($urandom_range(24'hFFFFFF, 1000)),
                  24'($urandom_range(2000, 1)));
    set_pressure(7);
    queue_random(150);
    wait_drained();

    apply_setting(24'd1, 24'd1, 24'd15, 24'hFFFFFF, 24'hFFFFFF);
    set_pressure(0);
    queue_random(100);
    wait_drained();

    if (freq_expected.size() != 0) begin
      $error("%0d expected result beats never arrived", freq_expected.size());
      n_errors = n_errors + 1;
    end
    $display("Ran %0d input beats and checked %0d result beats", n_in, n_out);
    $display("across %0d register settings and four handshake pressure modes", n_settings + 1);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/efa_pkg.sv
rtl/encoder_frequency_adjuster_core.sv
tb/tb_encoder_frequency_adjuster_core.sv
